// ----- rtl/wbps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants of the white/black point stretch block.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int SAMPLE_W = 32;
    localparam int POINT_W  = 14;
    localparam int LEVEL_W  = 17;

    // percent scale (hundredths of a percent) and output full scale
    localparam int PCT_SCALE = 10000;
    localparam int QBITS     = 16;           // quotient bits below 1.0
    localparam int QCNT_W    = $clog2(QBITS);

    // arithmetic widths of the apply path
    localparam int RANGE_W = SAMPLE_W + 1;
    localparam int FAC_W   = POINT_W + 1;
    localparam int PROD_W  = 48;
    localparam int WIDE    = 52;

    // apply queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_QW = $clog2(QDEPTH + 1);

    // register byte addresses
    localparam int ADDR_W = 3;
    localparam logic REG_BLACK = 1'b0;
    localparam logic REG_WHITE = 1'b1;

    localparam logic FUNC_SCAN  = 1'b0;
    localparam logic FUNC_APPLY = 1'b1;

    // one apply item with the statistics seen at its arrival
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] run_max;
        logic signed [SAMPLE_W-1:0] run_min;
    } t_item;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SUM,
        B_DIFF,
        B_CHECK,
        B_DIV,
        B_DONE
    } t_bstate;

endpackage : wbps_pkg
`default_nettype wire

// ----- rtl/wbps_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_front
// Accepts beats, keeps the running min/max, forwards apply beats to the queue.
// ----------------------------------------------------------------------------
module wbps_front #(
    parameter int FRAC_BITS = wbps_pkg::FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_accept,
    input  wire                                  i_func,
    input  wire signed [wbps_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire                                  i_frame_start,
    output logic                                 o_wr,
    output wbps_pkg::t_item                      o_item
);

    localparam logic [63:0] MinRaw = 64'd1000 << FRAC_BITS;
    localparam logic [wbps_pkg::SAMPLE_W-1:0] MinRst =
        (MinRaw > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : MinRaw[wbps_pkg::SAMPLE_W-1:0];

    logic signed [wbps_pkg::SAMPLE_W-1:0] r_run_max, n_run_max;
    logic signed [wbps_pkg::SAMPLE_W-1:0] r_run_min, n_run_min;
    logic signed [wbps_pkg::SAMPLE_W-1:0] w_base_max, w_base_min;

    always_comb begin
        w_base_max = i_frame_start ? '0 : r_run_max;
        w_base_min = i_frame_start ? $signed(MinRst) : r_run_min;
        n_run_max  = w_base_max;
        n_run_min  = w_base_min;
        // negative samples do not count
        if (!i_sample[wbps_pkg::SAMPLE_W-1]) begin
            if (i_sample > w_base_max) begin
                n_run_max = i_sample;
            end
            if (i_sample < w_base_min) begin
                n_run_min = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_max <= '0;
            r_run_min <= $signed(MinRst);
        end else if (i_accept && i_func == wbps_pkg::FUNC_SCAN) begin
            r_run_max <= n_run_max;
            r_run_min <= n_run_min;
        end
    end

    assign o_wr           = i_accept && i_func == wbps_pkg::FUNC_APPLY;
    assign o_item.sample  = i_sample;
    assign o_item.run_max = r_run_max;
    assign o_item.run_min = r_run_min;

endmodule : wbps_front
`default_nettype wire

// ----- rtl/wbps_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_queue
// Short FIFO of apply items between the front and the back.
// ----------------------------------------------------------------------------
module wbps_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_wr,
    input  wbps_pkg::t_item  i_wdata,
    input  wire              i_rd,
    output logic             o_full,
    output logic             o_valid,
    output wbps_pkg::t_item  o_rdata
);

    wbps_pkg::t_item r_mem [wbps_pkg::QDEPTH];
    logic [wbps_pkg::QPTR_W-1:0]  r_wptr, r_rptr;
    logic [wbps_pkg::QCNT_QW-1:0] r_cnt;
    logic w_wr, w_rd;

    assign o_full  = r_cnt == wbps_pkg::QCNT_QW'(wbps_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && o_valid;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule : wbps_queue
`default_nettype wire

// ----- rtl/wbps_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wbps_back
// Sequencer that maps one apply item to a level, with its own result register.
// ----------------------------------------------------------------------------
module wbps_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_q_valid,
    input  wbps_pkg::t_item                     i_q_item,
    output logic                                o_q_rd,
    input  wire  [wbps_pkg::POINT_W-1:0]        i_black,
    input  wire  [wbps_pkg::POINT_W-1:0]        i_white,
    input  wire                                 i_pop,
    output logic                                o_valid,
    output logic [wbps_pkg::LEVEL_W-1:0]        o_level,
    output logic                                o_degenerate
);

    localparam int PW = wbps_pkg::PROD_W;
    localparam int WW = wbps_pkg::WIDE;
    localparam logic signed [wbps_pkg::FAC_W-1:0] Scale = wbps_pkg::FAC_W'(wbps_pkg::PCT_SCALE);
    localparam logic [wbps_pkg::LEVEL_W-1:0] LevelOne = wbps_pkg::LEVEL_W'(1) << wbps_pkg::QBITS;

    wbps_pkg::t_bstate r_state, n_state;

    logic signed [wbps_pkg::RANGE_W-1:0] r_range;
    logic signed [WW-1:0] r_smax, r_smin, r_ss, r_lop, r_hip, r_lo, r_hi, r_span, r_d;
    logic [wbps_pkg::QBITS-1:0]   r_q;
    logic [wbps_pkg::QCNT_W-1:0]  r_cnt;
    logic [wbps_pkg::LEVEL_W-1:0] r_level;
    logic                         r_degen;
    logic                         r_out_valid;
    logic [wbps_pkg::LEVEL_W-1:0] r_out_level;
    logic                         r_out_degen;

    logic signed [PW-1:0] w_pmax, w_pmin, w_ps, w_plo, w_phi;
    logic signed [wbps_pkg::FAC_W-1:0] w_bfac, w_wfac;
    logic [WW-1:0] w_shift;
    logic          w_ge;
    logic          w_slot_free;
    logic          w_span_bad, w_d_low, w_d_high;

    // scale by 10000 and by the point factors
    assign w_pmax = i_q_item.run_max * Scale;
    assign w_pmin = i_q_item.run_min * Scale;
    assign w_ps   = i_q_item.sample  * Scale;
    assign w_bfac = $signed({1'b0, i_black});
    assign w_wfac = Scale - $signed({1'b0, i_white});
    assign w_plo  = r_range * w_bfac;
    assign w_phi  = r_range * w_wfac;

    assign w_span_bad = r_span[WW-1] || r_span == '0;
    assign w_d_low    = r_d[WW-1] || r_d == '0;
    assign w_d_high   = r_d >= r_span;

    // one restoring division step, remainder stays below the span
    assign w_shift = {r_d[WW-2:0], 1'b0};
    assign w_ge    = w_shift >= $unsigned(r_span);

    assign w_slot_free = !r_out_valid || i_pop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wbps_pkg::B_IDLE:  if (i_q_valid) n_state = wbps_pkg::B_MUL;
            wbps_pkg::B_MUL:   n_state = wbps_pkg::B_SUM;
            wbps_pkg::B_SUM:   n_state = wbps_pkg::B_DIFF;
            wbps_pkg::B_DIFF:  n_state = wbps_pkg::B_CHECK;
            wbps_pkg::B_CHECK: begin
                if (w_span_bad || w_d_low || w_d_high) begin
                    n_state = wbps_pkg::B_DONE;
                end else begin
                    n_state = wbps_pkg::B_DIV;
                end
            end
            wbps_pkg::B_DIV:   if (r_cnt == '0) n_state = wbps_pkg::B_DONE;
            wbps_pkg::B_DONE:  if (w_slot_free) n_state = wbps_pkg::B_IDLE;
            default:           n_state = wbps_pkg::B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_q_rd = 1'b0;
        case (r_state)
            wbps_pkg::B_IDLE: o_q_rd = i_q_valid;
            default:          o_q_rd = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wbps_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            wbps_pkg::B_IDLE: begin
                r_range <= wbps_pkg::RANGE_W'(i_q_item.run_max) -
                           wbps_pkg::RANGE_W'(i_q_item.run_min);
                r_smax  <= {{(WW-PW){w_pmax[PW-1]}}, w_pmax};
                r_smin  <= {{(WW-PW){w_pmin[PW-1]}}, w_pmin};
                r_ss    <= {{(WW-PW){w_ps[PW-1]}}, w_ps};
            end
            wbps_pkg::B_MUL: begin
                r_lop <= {{(WW-PW){w_plo[PW-1]}}, w_plo};
                r_hip <= {{(WW-PW){w_phi[PW-1]}}, w_phi};
            end
            wbps_pkg::B_SUM: begin
                r_lo <= r_smin + r_lop;
                r_hi <= r_smax - r_hip;
            end
            wbps_pkg::B_DIFF: begin
                r_span <= r_hi - r_lo;
                r_d    <= r_ss - r_lo;
            end
            wbps_pkg::B_CHECK: begin
                r_q   <= '0;
                r_cnt <= wbps_pkg::QCNT_W'(wbps_pkg::QBITS - 1);
                r_degen <= w_span_bad;
                if (w_span_bad || w_d_low) begin
                    r_level <= '0;
                end else begin
                    r_level <= LevelOne;
                end
            end
            wbps_pkg::B_DIV: begin
                r_d   <= w_ge ? $signed(w_shift - $unsigned(r_span)) : $signed(w_shift);
                r_q   <= {r_q[wbps_pkg::QBITS-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_level <= {1'b0, r_q[wbps_pkg::QBITS-2:0], w_ge};
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == wbps_pkg::B_DONE && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wbps_pkg::B_DONE && w_slot_free) begin
            r_out_level <= r_level;
            r_out_degen <= r_degen;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_level      = r_out_level;
    assign o_degenerate = r_out_degen;

endmodule : wbps_back
`default_nettype wire

// ----- rtl/white_black_point_stretch.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// white_black_point_stretch
// Two-pass auto-levels: running min/max scan and white/black point stretch.
// ----------------------------------------------------------------------------
// Push scan beats (func 0) to build the running minimum and maximum of all
// non-negative samples; frame_start on a scan beat restarts the statistics
// (max 0, min 1000.0). Push apply beats (func 1) to get one result beat each:
// the sample mapped so the adjusted black point gives 0 and the adjusted white
// point gives 1.0 (level 65536), clamped, with degenerate set and level 0 when
// the adjusted range is not positive. Scan beats are absorbed at one per
// cycle while the apply queue has room. Each apply beat carries the statistics
// current at its arrival into a four-entry queue; a back-end sequencer then
// runs the range arithmetic (mul, sum, diff, check) and, only when the level
// falls strictly between 0 and 1.0, a one-bit-per-cycle restoring divider;
// it takes the next item only after the last result enters the result
// register. full rises only when the apply queue fills. Write black_point
// (0x0) and white_point (0x4) only while the block is idle.
// ----------------------------------------------------------------------------
module white_black_point_stretch #(
    parameter int FRAC_BITS = wbps_pkg::FRAC_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // item channel
    input  wire                                  push,
    output logic                                 full,
    input  wire                                  i_func,
    input  wire signed [wbps_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire                                  i_frame_start,
    // result channel
    output logic                                 empty,
    input  wire                                  pop,
    output logic [wbps_pkg::LEVEL_W-1:0]         o_level,
    output logic                                 o_degenerate,
    // configuration port
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [wbps_pkg::ADDR_W-1:0]          paddr,
    input  wire  [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic [wbps_pkg::POINT_W-1:0] r_black, r_white;
    logic            w_accept;
    logic            w_q_wr, w_q_rd, w_q_valid, w_q_full;
    wbps_pkg::t_item w_wr_item, w_rd_item;
    logic            w_out_valid;

    // configuration registers; byte address bit 2 picks the register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black <= '0;
            r_white <= wbps_pkg::POINT_W'(9500);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == wbps_pkg::REG_BLACK) begin
                r_black <= pwdata[wbps_pkg::POINT_W-1:0];
            end else begin
                r_white <= pwdata[wbps_pkg::POINT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == wbps_pkg::REG_WHITE) ?
                    {{(32-wbps_pkg::POINT_W){1'b0}}, r_white} :
                    {{(32-wbps_pkg::POINT_W){1'b0}}, r_black};

    // take a beat whenever the apply queue has room
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    wbps_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_func        (i_func),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .o_wr          (w_q_wr),
        .o_item        (w_wr_item)
    );

    wbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_wr_item),
        .i_rd    (w_q_rd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_rdata (w_rd_item)
    );

    wbps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_rd_item),
        .o_q_rd       (w_q_rd),
        .i_black      (r_black),
        .i_white      (r_white),
        .i_pop        (pop),
        .o_valid      (w_out_valid),
        .o_level      (o_level),
        .o_degenerate (o_degenerate)
    );

    assign empty = !w_out_valid;

endmodule : white_black_point_stretch
`default_nettype wire

// ----- tb/sv/white_black_point_stretch_test.sv -----
// ----------------------------------------------------------------------------
// white_black_point_stretch_test
// Self-checking bench for the two-pass auto-levels stretch block.
// ----------------------------------------------------------------------------
// Scan beats feed a local copy of the running minimum and maximum. Every
// accepted apply beat is turned into one expected level with exact 64-bit
// integer arithmetic, and each popped result is checked against the oldest
// one. The run opens with a short directed pass and a sweep of register
// extremes, then streams random frames under three idling patterns, and
// once starves the result side long enough for the input to back up.
// ----------------------------------------------------------------------------
module white_black_point_stretch_test;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 40;      // margin for the back end to finish its last item
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int MAX_REPORTS    = 10;

    localparam longint LEVEL_ONE = 65536;
    localparam logic signed [wbps_pkg::SAMPLE_W-1:0] STAT_MIN_RESET =
        wbps_pkg::SAMPLE_W'(1000 * (1 << wbps_pkg::FRAC_BITS_DEF));

    typedef struct {
        logic [wbps_pkg::LEVEL_W-1:0] level;
        logic                         degenerate;
    } t_stretch_result;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                                 i_clk;
    logic                                 i_rst_n       = 1'b0;
    logic                                 push          = 1'b0;
    logic                                 full;
    logic                                 i_func        = wbps_pkg::FUNC_SCAN;
    logic signed [wbps_pkg::SAMPLE_W-1:0] i_sample      = '0;
    logic                                 i_frame_start = 1'b0;
    logic                                 empty;
    logic                                 pop           = 1'b0;
    logic [wbps_pkg::LEVEL_W-1:0]         o_level;
    logic                                 o_degenerate;
    logic                                 psel          = 1'b0;
    logic                                 penable       = 1'b0;
    logic                                 pwrite        = 1'b0;
    logic [wbps_pkg::ADDR_W-1:0]          paddr         = '0;
    logic [31:0]                          pwdata        = '0;
    logic [31:0]                          prdata;
    logic                                 pready;

    white_black_point_stretch u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_func        (i_func),
        .i_sample      (i_sample),
        .i_frame_start (i_frame_start),
        .empty         (empty),
        .pop           (pop),
        .o_level       (o_level),
        .o_degenerate  (o_degenerate),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor state: registers and running statistics as the block holds them
    // ------------------------------------------------------------------------
    logic [wbps_pkg::POINT_W-1:0]         black_pct = wbps_pkg::POINT_W'(0);
    logic [wbps_pkg::POINT_W-1:0]         white_pct = wbps_pkg::POINT_W'(9500);
    logic signed [wbps_pkg::SAMPLE_W-1:0] stat_max  = '0;
    logic signed [wbps_pkg::SAMPLE_W-1:0] stat_min  = STAT_MIN_RESET;

    t_stretch_result pending_levels[$];

    // traffic knobs, owned by the test sequence
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req    = 0;     // bump to start one long result-side hold-off
    int hold_len    = 0;

    // bookkeeping
    int err_count     = 0;
    int n_scan        = 0;
    int n_apply       = 0;
    int n_results     = 0;
    int n_degen       = 0;
    int n_black       = 0;
    int n_white       = 0;
    int n_full_cycles = 0;
    int n_writes      = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout: %0d results still expected", pending_levels.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stretch of one apply sample against the current statistics. Every term is
    // kept scaled by 10000 so the black and white points stay exact integers.
    // ------------------------------------------------------------------------
    function automatic t_stretch_result stretch_level(
        input logic signed [wbps_pkg::SAMPLE_W-1:0] smp);
        longint          rng;
        longint          lo;
        longint          hi;
        longint          span;
        longint          d;
        t_stretch_result r;
        rng  = longint'(stat_max) - longint'(stat_min);
        lo   = longint'(stat_min) * wbps_pkg::PCT_SCALE + rng * longint'(black_pct);
        hi   = longint'(stat_max) * wbps_pkg::PCT_SCALE -
               rng * (wbps_pkg::PCT_SCALE - longint'(white_pct));
        span = hi - lo;
        r.level      = '0;
        r.degenerate = 1'b0;
        if (span <= 0) begin
            // points met or crossed: flag it and force black
            r.degenerate = 1'b1;
        end else begin
            d = longint'(smp) * wbps_pkg::PCT_SCALE - lo;
            if (d >= span) begin
                r.level = wbps_pkg::LEVEL_W'(LEVEL_ONE);
            end else if (d > 0) begin
                r.level = wbps_pkg::LEVEL_W'((d * LEVEL_ONE) / span);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check popped results, then track accepted beats and writes.
    // Everything is sampled at the rising edge, before the block updates.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_stretch_result want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                n_results++;
                if (pending_levels.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("unexpected result beat: level %0d degenerate %0d",
                                 o_level, o_degenerate);
                end else begin
                    want = pending_levels.pop_front();
                    if (o_level !== want.level || o_degenerate !== want.degenerate) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display("result %0d: level exp %0d got %0d, degenerate exp %0d got %0d",
                                     n_results, want.level, o_level,
                                     want.degenerate, o_degenerate);
                    end
                end
            end

            if (push && full)
                n_full_cycles++;

            if (push && !full) begin
                if (i_func == wbps_pkg::FUNC_SCAN) begin
                    n_scan++;
                    // frame start clears the statistics before this sample counts
                    if (i_frame_start) begin
                        stat_max = '0;
                        stat_min = STAT_MIN_RESET;
                    end
                    if (!i_sample[wbps_pkg::SAMPLE_W-1]) begin
                        if (i_sample > stat_max) stat_max = i_sample;
                        if (i_sample < stat_min) stat_min = i_sample;
                    end
                end else begin
                    // frame_start means nothing on an apply beat
                    n_apply++;
                    want = stretch_level(i_sample);
                    if (want.degenerate) n_degen++;
                    else if (want.level == '0) n_black++;
                    else if (want.level == wbps_pkg::LEVEL_W'(LEVEL_ONE)) n_white++;
                    pending_levels.push_back(want);
                end
            end

            if (psel && penable && pwrite && pready) begin
                if (paddr == {wbps_pkg::REG_BLACK, 2'b00})
                    black_pct = pwdata[wbps_pkg::POINT_W-1:0];
                else if (paddr == {wbps_pkg::REG_WHITE, 2'b00})
                    white_pct = pwdata[wbps_pkg::POINT_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: pop at random, or hold off for a counted stretch on request.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Offer one beat and return at the edge that takes it. full is sampled at
    // the falling edge, where it is settled for the coming rising edge.
    task automatic send_beat(input logic fn, input logic signed [wbps_pkg::SAMPLE_W-1:0] smp,
                             input logic fs);
        logic stalled;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            // drop push and wiggle the payload; the block must ignore it
            push          <= 1'b0;
            i_func        <= 1'($urandom);
            i_sample      <= $urandom;
            i_frame_start <= 1'($urandom);
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        push          <= 1'b1;
        i_func        <= fn;
        i_sample      <= smp;
        i_frame_start <= fs;
        do begin
            @(negedge i_clk);
            stalled = full;
            @(posedge i_clk);
        end while (stalled);
    endtask

    // Setup and access phase of one register write; junk in the upper bits.
    task automatic write_reg(input logic idx, input logic [wbps_pkg::POINT_W-1:0] val);
        logic ready;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {(32 - wbps_pkg::POINT_W)'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready = pready;
            @(posedge i_clk);
        end while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every expected beat, then let the back end settle.
    // The first edge lets the monitor book the last accepted beat.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_points(input logic [wbps_pkg::POINT_W-1:0] bp,
                              input logic [wbps_pkg::POINT_W-1:0] wp);
        drain_results();
        write_reg(wbps_pkg::REG_BLACK, bp);
        write_reg(wbps_pkg::REG_WHITE, wp);
    endtask

    // Mostly in-range samples; one in ten is any 32-bit value, negatives too.
    function automatic logic signed [wbps_pkg::SAMPLE_W-1:0] rand_sample(
        input int unsigned top);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, top);
    endfunction

    // One frame: a scan burst opened by frame start, then applies. A few frames
    // skip the scans or the frame start to exercise stale statistics.
    task automatic run_frame(output int count);
        int          scans;
        int          applies;
        int          shape;
        int unsigned top;
        int          i;
        shape   = $urandom_range(0, 99);
        scans   = (shape < 8) ? 0 : $urandom_range(1, 9);
        applies = $urandom_range(1, 8);
        case ($urandom_range(0, 3))
            0:       top = 32'h7FFF_FFFF;
            1:       top = 32'h00FF_FFFF;
            2:       top = 32'h0000_FFFF;
            default: top = 32'd3;
        endcase
        for (i = 0; i < scans; i++)
            send_beat(wbps_pkg::FUNC_SCAN, rand_sample(top),
                      (i == 0) ? (shape >= 15) : ($urandom_range(0, 99) < 3));
        for (i = 0; i < applies; i++)
            send_beat(wbps_pkg::FUNC_APPLY, rand_sample(top), 1'($urandom));
        count = scans + applies;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset points (black 0, white 9500): stale statistics, sample extremes,
    // negatives ignored by the scan, a zero range and a negative-only frame.
    task automatic test_directed();
        send_beat(wbps_pkg::FUNC_APPLY, 32'sd0, 1'b1);                // no scan yet
        send_beat(wbps_pkg::FUNC_SCAN, 32'sh7FFF_FFFF, 1'b1);
        send_beat(wbps_pkg::FUNC_SCAN, 32'sd0, 1'b0);
        send_beat(wbps_pkg::FUNC_SCAN, 32'sh8000_0000, 1'b0);          // negative, skipped
        send_beat(wbps_pkg::FUNC_SCAN, 32'shFFFF_FFFF, 1'b0);
        send_beat(wbps_pkg::FUNC_APPLY, 32'sh8000_0000, 1'b0);         // far below black
        send_beat(wbps_pkg::FUNC_APPLY, 32'shFFFF_FFFF, 1'b1);
        send_beat(wbps_pkg::FUNC_APPLY, 32'sd0, 1'b0);                 // on the black point
        send_beat(wbps_pkg::FUNC_APPLY, 32'sd1, 1'b0);
        send_beat(wbps_pkg::FUNC_APPLY, 32'sh4000_0000, 1'b0);
        send_beat(wbps_pkg::FUNC_APPLY, 32'sh7999_9999, 1'b0);         // near white
        send_beat(wbps_pkg::FUNC_APPLY, 32'sh7FFF_FFFF, 1'b1);         // past white
        send_beat(wbps_pkg::FUNC_SCAN, 32'sd5 <<< 16, 1'b1);           // single sample: zero range
        send_beat(wbps_pkg::FUNC_APPLY, 32'sd5 <<< 16, 1'b0);
        send_beat(wbps_pkg::FUNC_SCAN, STAT_MIN_RESET, 1'b1);          // max meets reset min
        send_beat(wbps_pkg::FUNC_APPLY, STAT_MIN_RESET, 1'b0);
        send_beat(wbps_pkg::FUNC_SCAN, 32'shFFFF_0000, 1'b1);          // negative-only frame
        send_beat(wbps_pkg::FUNC_APPLY, 32'sd7, 1'b0);
    endtask

    // Sweep both registers through their extremes, including values past
    // 10000 and crossed points, with a couple of frames at each setting.
    task automatic test_register_extremes();
        logic [wbps_pkg::POINT_W-1:0] bp_list[6];
        logic [wbps_pkg::POINT_W-1:0] wp_list[6];
        int                           i;
        int                           j;
        int                           cnt;
        bp_list = '{wbps_pkg::POINT_W'(0),     wbps_pkg::POINT_W'(10000),
                    wbps_pkg::POINT_W'(16383), wbps_pkg::POINT_W'(0),
                    wbps_pkg::POINT_W'(5000),  wbps_pkg::POINT_W'(16383)};
        wp_list = '{wbps_pkg::POINT_W'(10000), wbps_pkg::POINT_W'(10000),
                    wbps_pkg::POINT_W'(0),     wbps_pkg::POINT_W'(16383),
                    wbps_pkg::POINT_W'(5000),  wbps_pkg::POINT_W'(16383)};
        for (i = 0; i < 6; i++) begin
            set_points(bp_list[i], wp_list[i]);
            for (j = 0; j < 2; j++) run_frame(cnt);
        end
    endtask

    // Random frames under one idling pattern, with fresh points up front.
    task automatic test_random_frames(input int n_items, input int tx_pct, input int rx_pct);
        int sent;
        int cnt;
        if ($urandom_range(0, 9) < 7)
            set_points(wbps_pkg::POINT_W'($urandom_range(0, 1500)),
                       wbps_pkg::POINT_W'($urandom_range(8500, 10000)));
        else
            set_points(wbps_pkg::POINT_W'($urandom), wbps_pkg::POINT_W'($urandom));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            run_frame(cnt);
            sent += cnt;
        end
    endtask

    // Starve the result side for a long stretch while applies keep coming,
    // so the apply queue fills and full holds the input.
    task automatic test_backpressure();
        int i;
        set_points(wbps_pkg::POINT_W'(250), wbps_pkg::POINT_W'(9750));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_beat(wbps_pkg::FUNC_SCAN, 32'sd2 <<< 16, 1'b1);
        send_beat(wbps_pkg::FUNC_SCAN, 32'sd200 <<< 16, 1'b0);
        hold_len = 400;
        hold_req++;
        for (i = 0; i < 40; i++)
            send_beat(wbps_pkg::FUNC_APPLY, rand_sample(32'd210 << 16), 1'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : sequence_main
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 36;
        rx_idle_pct = 86;
        test_directed();
        test_register_extremes();
        test_random_frames(400, 36, 86);
        test_random_frames(400, 86, 36);
        test_backpressure();
        test_random_frames(300, 0, 0);

        drain_results();
        if (pending_levels.size() != 0) begin
            err_count++;
            $display("%0d expected results never arrived", pending_levels.size());
        end
        if (err_count != 0)
            $display("%0d mismatches in total", err_count);

        $display("Covered %0d scan and %0d apply beats over %0d register writes; %0d results checked.",
                 n_scan, n_apply, n_writes, n_results);
        $display("Degenerate %0d, clamped black %0d, clamped white %0d; input held by full %0d cycles.",
                 n_degen, n_black, n_white, n_full_cycles);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
